>>> sv/eave_pkg.sv
package eave_pkg;

	localparam int ENC_W    = 40;
	localparam int FRAC     = 24;
	localparam int SCALE_SH = 40 - FRAC;
	localparam int OUT_W    = 48;
	localparam int MA_W     = 49;              // multiplicand, signed
	localparam int MB_W     = 41;              // multiplier, signed
	localparam int MUL_STEPS = MB_W - 1;       // one multiplier bit per cycle
	localparam int PROD_W   = MA_W + MB_W;     // signed product
	localparam int MOD_W    = 74;              // dividend magnitude for the turn reduction
	localparam int REM_W    = 27;
	localparam int CNT_W    = 7;

	localparam logic [63:0] PI_Q64 = (64'h3243F6A8885A3 + (64'd1 << 23)) >> 24;
	localparam logic [REM_W-1:0] PI_Q     = PI_Q64[REM_W-1:0];
	localparam logic [REM_W-1:0] TWO_PI_Q = {PI_Q64[REM_W-2:0], 1'b0};

	localparam logic [2:0] REG_MOTOR_ZERO  = 3'd0;
	localparam logic [2:0] REG_TORS_OFFSET = 3'd1;
	localparam logic [2:0] REG_SCALE       = 3'd2;
	localparam logic [2:0] REG_INV_GEAR    = 3'd3;
	localparam logic [2:0] REG_MOTOR_GAIN  = 3'd4;
	localparam logic [2:0] REG_MOTOR_COEF  = 3'd5;
	localparam logic [2:0] REG_TORS_GAIN   = 3'd6;
	localparam logic [2:0] REG_TORS_COEF   = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MRAW,
		S_MODR,
		S_MODP,
		S_UNW,
		S_MGEAR,
		S_MTORS,
		S_FU,
		S_FB,
		S_FY,
		S_DONE
	} state_t;

	localparam logic signed [91:0] SAT_MAX = 92'sd140737488355327;
	localparam logic signed [91:0] SAT_MIN = -92'sd140737488355328;

	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [91:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[OUT_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[OUT_W-1:0];
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> sv/encoder_angle_velocity_estimator_top.sv
// Encoder angle and velocity estimator. Each request on the slave stream carries one pair of
// raw 40-bit encoder counts (motor, torsion spring); one result request on the master stream
// returns the geared, turn-unwrapped motor angle, the torsion angle and both filtered
// velocities, all signed Q24.24 and saturated to 48 bits. The block works on one sample at a
// time: a single shift-add multiplier (one multiplier bit per cycle) does all nine products and a
// restoring reduction unit (one dividend bit per cycle) folds the raw and previous angles into
// one turn. No new sample is taken until the result of the last one has been loaded into the
// output register, so the sustained sample rate is set by the nine serial products and the
// two serial turn reductions, which run one after another.
// A finished result waits in the output register while the next sample is taken.
// Configuration writes (cfg_we, cfg_addr, cfg_data) should be made only while idle.
module encoder_angle_velocity_estimator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // motor_raw[39:0], torsion_raw[79:40]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // motor_angle, motor_velocity, torsion_angle,
	                                // torsion_velocity, 48 bits each from bit 0 up
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [40:0]  cfg_data
);
	import eave_pkg::*;

	// configuration
	logic [ENC_W-1:0]        zero_q;
	logic signed [ENC_W:0]   offset_q;
	logic [39:0]             scale_q;
	logic [31:0]             igr_q;
	logic [15:0]             mf_q, tf_q;
	logic [FRAC-1:0]         mb_q, tb_q;

	// filter and unwrap state
	logic signed [OUT_W-1:0] prev_q, mup_q, myp_q, tup_q, typ_q;

	// sequencer
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             ch_q;
	logic             mul_done, mod_done, out_free;

	// working registers
	logic signed [ENC_W:0]   dm_q;
	logic signed [ENC_W+1:0] e_q;
	logic signed [MOD_W-1:0] raw_q;
	logic [REM_W-1:0]        rm_q, pm_q;
	logic signed [OUT_W-1:0] mang_q, tang_q, u_q, mvel_q, tvel_q;
	logic signed [PROD_W-1:0] acc_q;

	// serial multiplier
	logic [MA_W-1:0]       ma_q;
	logic [MA_W-1:0]       ph_q;
	logic [MUL_STEPS-1:0]  pl_q;
	logic                  neg_q;
	logic signed [MA_W-1:0] op_a;
	logic signed [MB_W-1:0] op_b;
	logic [MA_W:0]         mul_sum;
	logic [PROD_W-1:0]     prod_mag;
	logic signed [PROD_W-1:0] prod_s;

	// serial turn reduction
	logic [MOD_W-1:0]        md_q;
	logic [REM_W-1:0]        rem_q;
	logic                    mneg_q;
	logic signed [MOD_W-1:0] mod_op;
	logic [REM_W:0]          rem_t;
	logic [REM_W-1:0]        mod_res;

	// output register
	logic         ovalid_q;
	logic [191:0] odata_q;

	// combinational helpers
	logic [REM_W:0]          w0;
	logic signed [REM_W+1:0] w;
	logic signed [OUT_W-1:0] unw;
	logic signed [OUT_W-1:0] y_new, vel_new, up_sel, yp_sel;
	logic [FRAC-1:0]         b_sel;
	logic [15:0]             f_sel;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	assign mul_done = (cnt_q == CNT_W'(MUL_STEPS + 1));
	assign mod_done = (cnt_q == CNT_W'(MOD_W + 1));
	assign out_free = !ovalid_q || m_tready;

	assign up_sel = ch_q ? tup_q : mup_q;
	assign yp_sel = ch_q ? typ_q : myp_q;
	assign b_sel  = ch_q ? tb_q : mb_q;
	assign f_sel  = ch_q ? tf_q : mf_q;

	// operand selection for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_MRAW: begin
				op_a = MA_W'(dm_q);
				op_b = MB_W'({1'b0, scale_q});
			end
			S_MGEAR: begin
				op_a = MA_W'(prev_q);
				op_b = MB_W'({1'b0, igr_q});
			end
			S_MTORS: begin
				op_a = MA_W'(e_q);
				op_b = MB_W'({1'b0, scale_q});
			end
			S_FU: begin
				op_a = MA_W'(ch_q ? tang_q : mang_q);
				op_b = MB_W'({1'b0, f_sel});
			end
			S_FB: begin
				op_a = MA_W'(u_q) + MA_W'(up_sel);
				op_b = MB_W'({1'b0, b_sel});
			end
			S_FY: begin
				op_a = MA_W'(yp_sel);
				op_b = (MB_W'(1) << FRAC) - {{(MB_W - FRAC - 1){1'b0}}, b_sel, 1'b0};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_sum  = {1'b0, ph_q} + (pl_q[0] ? {1'b0, ma_q} : '0);
	assign prod_mag = {1'b0, ph_q, pl_q};
	assign prod_s   = neg_q ? -$signed(prod_mag) : $signed(prod_mag);

	assign mod_op  = (state_q == S_MODR) ? raw_q : MOD_W'(prev_q);
	assign rem_t   = {rem_q, md_q[MOD_W-1]};
	assign mod_res = (mneg_q && rem_q != '0) ? TWO_PI_Q - rem_q : rem_q;

	// unwrap: step from previous angle, folded into (-pi, pi]
	assign w0  = (rm_q >= pm_q) ? {1'b0, rm_q} - {1'b0, pm_q}
	                            : {1'b0, rm_q} + {1'b0, TWO_PI_Q} - {1'b0, pm_q};
	assign w   = (w0 > {1'b0, PI_Q}) ? $signed({1'b0, w0}) - $signed({2'b0, TWO_PI_Q})
	                                 : $signed({1'b0, w0});
	assign unw = sat48(92'(prev_q) + 92'(w));

	// dirty-derivative output, acc_q holds b*(u + u_prev)
	assign y_new   = sat48((92'(acc_q) + 92'(prod_s)) >>> FRAC);
	assign vel_new = sat48(92'(u_q) - 92'(y_new));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_MRAW;
			S_MRAW:  if (mul_done) state_d = S_MODR;
			S_MODR:  if (mod_done) state_d = S_MODP;
			S_MODP:  if (mod_done) state_d = S_UNW;
			S_UNW:   state_d = S_MGEAR;
			S_MGEAR: if (mul_done) state_d = S_MTORS;
			S_MTORS: if (mul_done) state_d = S_FU;
			S_FU:    if (mul_done) state_d = S_FB;
			S_FB:    if (mul_done) state_d = S_FY;
			S_FY:    if (mul_done) state_d = ch_q ? S_DONE : S_FU;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ch_q     <= 1'b0;
			ovalid_q <= 1'b0;
			zero_q   <= '0;
			offset_q <= '0;
			scale_q  <= '0;
			igr_q    <= 32'd16777216;
			mf_q     <= 16'd1000;
			mb_q     <= 24'd3355443;
			tf_q     <= 16'd300;
			tb_q     <= 24'd1170503;
			prev_q   <= '0;
			mup_q    <= '0;
			myp_q    <= '0;
			tup_q    <= '0;
			typ_q    <= '0;
		end else begin
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q != S_IDLE && state_q != S_DONE && state_q != S_UNW) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (state_q == S_IDLE) begin
				ch_q <= 1'b0;
			end else if (state_q == S_FY && mul_done) begin
				ch_q <= 1'b1;
			end

			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_addr)
					REG_MOTOR_ZERO:  zero_q   <= cfg_data[ENC_W-1:0];
					REG_TORS_OFFSET: offset_q <= $signed(cfg_data);
					REG_SCALE:       scale_q  <= cfg_data[39:0];
					REG_INV_GEAR:    igr_q    <= cfg_data[31:0];
					REG_MOTOR_GAIN:  mf_q     <= cfg_data[15:0];
					REG_MOTOR_COEF:  mb_q     <= cfg_data[FRAC-1:0];
					REG_TORS_GAIN:   tf_q     <= cfg_data[15:0];
					REG_TORS_COEF:   tb_q     <= cfg_data[FRAC-1:0];
					default: ;
				endcase
			end

			if (state_q == S_UNW) begin
				prev_q <= unw;
			end

			if (state_q == S_FY && mul_done) begin
				if (ch_q) begin
					tup_q <= u_q;
					typ_q <= y_new;
				end else begin
					mup_q <= u_q;
					myp_q <= y_new;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dm_q <= $signed({1'b0, s_tdata[ENC_W-1:0]}) - $signed({1'b0, zero_q});
			e_q  <= $signed({2'b0, s_tdata[2*ENC_W-1:ENC_W]}) - (ENC_W+2)'(offset_q);
		end

		// multiplier: load magnitudes at count 0, then one bit per cycle
		if (cnt_q == '0) begin
			ma_q  <= op_a[MA_W-1] ? MA_W'(-op_a) : op_a;
			pl_q  <= op_b[MB_W-1] ? MUL_STEPS'(-op_b) : op_b[MUL_STEPS-1:0];
			ph_q  <= '0;
			neg_q <= op_a[MA_W-1] ^ op_b[MB_W-1];
		end else if (cnt_q <= CNT_W'(MUL_STEPS)) begin
			ph_q <= mul_sum[MA_W:1];
			pl_q <= {mul_sum[0], pl_q[MUL_STEPS-1:1]};
		end

		// turn reduction: restoring, one dividend bit per cycle
		if (cnt_q == '0) begin
			md_q   <= mod_op[MOD_W-1] ? MOD_W'(-mod_op) : mod_op;
			mneg_q <= mod_op[MOD_W-1];
			rem_q  <= '0;
		end else if (cnt_q <= CNT_W'(MOD_W)) begin
			md_q  <= {md_q[MOD_W-2:0], 1'b0};
			rem_q <= (rem_t >= {1'b0, TWO_PI_Q}) ? REM_W'(rem_t - {1'b0, TWO_PI_Q})
			                                     : rem_t[REM_W-1:0];
		end

		case (state_q)
			S_MRAW:  if (mul_done) raw_q <= MOD_W'(prod_s >>> SCALE_SH);
			S_MODR:  if (mod_done) rm_q <= mod_res;
			S_MODP:  if (mod_done) pm_q <= mod_res;
			S_MGEAR: if (mul_done) mang_q <= sat48(92'(prod_s >>> FRAC));
			S_MTORS: if (mul_done) tang_q <= sat48(92'(prod_s >>> SCALE_SH));
			S_FU:    if (mul_done) u_q <= sat48(92'(prod_s));
			S_FB:    if (mul_done) acc_q <= prod_s;
			S_FY:    if (mul_done) begin
				if (ch_q) begin
					tvel_q <= vel_new;
				end else begin
					mvel_q <= vel_new;
				end
			end
			default: ;
		endcase

		// whole result word loads only once the previous one has left
		if (state_q == S_DONE && out_free) begin
			odata_q <= {tvel_q, tang_q, mvel_q, mang_q};
		end
	end

endmodule

>>> dv/encoder_angle_velocity_estimator_top_tb.sv
module encoder_angle_velocity_estimator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import eave_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [39:0] motor_raw;
		logic [39:0] torsion_raw;
	} sample_t;

	typedef struct {
		logic signed [47:0] motor_angle;
		logic signed [47:0] motor_velocity;
		logic signed [47:0] torsion_angle;
		logic signed [47:0] torsion_velocity;
	} estimate_t;

	// pi and a full turn in Q24.24, rounded from pi in Q.48
	localparam wide_t HALF_TURN = (128'h3243F6A8885A3 + (128'd1 << 23)) >>> 24;
	localparam wide_t FULL_TURN = 2 * HALF_TURN;
	localparam wide_t Q48_MAX = (128'sd1 <<< 47) - 1;
	localparam wide_t Q48_MIN = -(128'sd1 <<< 47);
	localparam int CYCLE_LIMIT = 12000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [79:0] s_tdata;       // motor_raw[39:0], torsion_raw[79:40]
	logic m_tvalid;
	logic m_tready;
	logic [191:0] m_tdata;      // motor_angle, motor_velocity, torsion_angle, torsion_velocity
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [40:0] cfg_data;

	encoder_angle_velocity_estimator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// estimator shadow: registers and filter state
	logic [39:0] zero_counts;
	logic signed [40:0] tors_offset;
	logic [39:0] scale_q40;
	logic [31:0] gear_q24;
	logic [15:0] motor_gain, tors_gain;
	logic [23:0] motor_coef, tors_coef;
	logic signed [47:0] last_unwrapped;
	logic signed [47:0] motor_u_prev, motor_y_prev, tors_u_prev, tors_y_prev;

	sample_t sample_q[$];      // requests waiting for the driver
	estimate_t estimate_q[$];  // predicted results, oldest first
	int errors = 0;
	int unsigned cycles = 0;
	bit took = 0;
	int gap_left = 0;
	int burst_left = 1;
	logic [15:0] ready_mask = '1;

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic logic signed [47:0] clamp48(input wide_t v);
		if (v > Q48_MAX) return Q48_MAX[47:0];
		if (v < Q48_MIN) return Q48_MIN[47:0];
		return v[47:0];
	endfunction

	// angle folded into [0, turn)
	function automatic wide_t turn_fold(input wide_t v);
		wide_t r;
		r = v % FULL_TURN;
		if (r < 0) r = r + FULL_TURN;
		return r;
	endfunction

	// dirty derivative: u = f*x, y = b*(u+u_prev) + (1-2b)*y_prev, rate = u - y
	function automatic logic signed [47:0] rate_filter(input wide_t x, input logic [15:0] f,
			input logic [23:0] b, inout logic signed [47:0] u_prev,
			inout logic signed [47:0] y_prev);
		wide_t fw, bw, u, y, acc;
		fw = f;
		bw = b;
		u = clamp48(x * fw);
		acc = (u + wide_t'(u_prev)) * bw + wide_t'(y_prev) * ((128'sd1 <<< 24) - 2 * bw);
		y = clamp48(acc >>> 24);
		u_prev = u[47:0];
		y_prev = y[47:0];
		return clamp48(u - y);
	endfunction

	function automatic estimate_t estimate_sample(input sample_t s);
		estimate_t r;
		wide_t d, e, sc, raw, rm, pm, w, unw;
		d = s.motor_raw;
		d = d - wide_t'(zero_counts);
		e = s.torsion_raw;
		e = e - wide_t'(tors_offset);
		sc = scale_q40;
		raw = (d * sc) >>> 16;
		rm = turn_fold(raw);
		pm = turn_fold(wide_t'(last_unwrapped));
		w = (rm >= pm) ? rm - pm : rm + FULL_TURN - pm;
		if (w > HALF_TURN) w = w - FULL_TURN;
		unw = clamp48(wide_t'(last_unwrapped) + w);
		last_unwrapped = unw[47:0];
		r.motor_angle = clamp48((unw * wide_t'({1'b0, gear_q24})) >>> 24);
		r.torsion_angle = clamp48((e * sc) >>> 16);
		r.motor_velocity = rate_filter(wide_t'(r.motor_angle), motor_gain, motor_coef,
			motor_u_prev, motor_y_prev);
		r.torsion_velocity = rate_filter(wide_t'(r.torsion_angle), tors_gain, tors_coef,
			tors_u_prev, tors_y_prev);
		return r;
	endfunction

	function automatic logic [40:0] rand41();
		return {9'($urandom_range(0, 511)), $urandom};
	endfunction

	// register write, made only while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [40:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_MOTOR_ZERO:  zero_counts = val[39:0];
			REG_TORS_OFFSET: tors_offset = val;
			REG_SCALE:       scale_q40 = val[39:0];
			REG_INV_GEAR:    gear_q24 = val[31:0];
			REG_MOTOR_GAIN:  motor_gain = val[15:0];
			REG_MOTOR_COEF:  motor_coef = val[23:0];
			REG_TORS_GAIN:   tors_gain = val[15:0];
			REG_TORS_COEF:   tors_coef = val[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(input logic [39:0] m, input logic [39:0] t);
		sample_t s;
		s.motor_raw = m;
		s.torsion_raw = t;
		sample_q.push_back(s);
	endtask

	// hold off until the block has returned everything
	task automatic drain();
		wait (sample_q.size() == 0 && estimate_q.size() == 0 && !s_tvalid);
		repeat (40) @(posedge clk);
	endtask

	// sender: bursts with random gaps, one request held until taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !took)) begin
			took = 0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				sample_t s;
				s = sample_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {s.torsion_raw, s.motor_raw};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600)
						: $urandom_range(0, 4);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stalls follow a 16-bit ready mask indexed by the cycle count, renewed whenever its low ten bits are zero
	always @(negedge clk) begin
		if (cycles[9:0] == 0)
			ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		m_tready <= ready_mask[cycles[3:0]];
	end

	// monitor: check results, predict each accepted request
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (estimate_q.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				estimate_t x;
				x = estimate_q.pop_front();
				if (m_tdata[47:0] !== x.motor_angle) begin
					$error("motor_angle exp %0d got %0d", x.motor_angle,
						$signed(m_tdata[47:0]));
					errors++;
				end
				if (m_tdata[95:48] !== x.motor_velocity) begin
					$error("motor_velocity exp %0d got %0d", x.motor_velocity,
						$signed(m_tdata[95:48]));
					errors++;
				end
				if (m_tdata[143:96] !== x.torsion_angle) begin
					$error("torsion_angle exp %0d got %0d", x.torsion_angle,
						$signed(m_tdata[143:96]));
					errors++;
				end
				if (m_tdata[191:144] !== x.torsion_velocity) begin
					$error("torsion_velocity exp %0d got %0d", x.torsion_velocity,
						$signed(m_tdata[191:144]));
					errors++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			sample_t s;
			s.motor_raw = s_tdata[39:0];
			s.torsion_raw = s_tdata[79:40];
			estimate_q.push_back(estimate_sample(s));
			took = 1;
		end
	end

	initial begin
		logic [39:0] mpos, tpos;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_data = '0;
		zero_counts = '0;
		tors_offset = '0;
		scale_q40 = '0;
		gear_q24 = 32'd16777216;
		motor_gain = 16'd1000;
		motor_coef = 24'd3355443;
		tors_gain = 16'd300;
		tors_coef = 24'd1170503;
		last_unwrapped = '0;
		motor_u_prev = '0;
		motor_y_prev = '0;
		tors_u_prev = '0;
		tors_y_prev = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// a few samples at reset defaults: scale zero gives all-zero angles
		push_sample(40'hFF_FFFF_FFFF, 40'h12_3456_789A);
		push_sample('0, '0);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				1: begin
					// one count per Q24.24 LSB: raw angle equals the count,
					// exact half-turn steps exercise the tie at pi
					write_reg(REG_MOTOR_ZERO, 41'h100_0000_0000);
					write_reg(REG_TORS_OFFSET, '0);
					write_reg(REG_SCALE, 41'd1 << 16);
					write_reg(REG_INV_GEAR, 41'd1 << 24);
				end
				2: begin
					write_reg(REG_MOTOR_ZERO, 41'h0FF_FFFF_FFFF);
					write_reg(REG_TORS_OFFSET, 41'h0FF_FFFF_FFFF);
					write_reg(REG_SCALE, 41'h0FF_FFFF_FFFF);
					write_reg(REG_INV_GEAR, 41'h0_FFFF_FFFF);
					write_reg(REG_MOTOR_GAIN, 41'hFFFF);
					write_reg(REG_MOTOR_COEF, 41'hFF_FFFF);
					write_reg(REG_TORS_GAIN, 41'hFFFF);
					write_reg(REG_TORS_COEF, 41'hFF_FFFF);
				end
				3: begin
					write_reg(REG_MOTOR_ZERO, '0);
					write_reg(REG_TORS_OFFSET, 41'h100_0000_0000);
					write_reg(REG_SCALE, 41'd1);
					write_reg(REG_INV_GEAR, '0);
					write_reg(REG_MOTOR_GAIN, 41'd1);
					write_reg(REG_MOTOR_COEF, '0);
					write_reg(REG_TORS_GAIN, 41'd1);
					write_reg(REG_TORS_COEF, '0);
				end
				default: begin
					// random settings, excess data bits included
					for (int r = 0; r < 8; r++) begin
						logic [40:0] v;
						v = rand41();
						if (r == REG_INV_GEAR && $urandom_range(0, 1))
							v = 41'($urandom_range(1 << 22, 1 << 25));
						if ((r == REG_MOTOR_GAIN || r == REG_TORS_GAIN) && v[15:0] == 0)
							v[0] = 1'b1;
						write_reg(3'(r), v);
					end
				end
			endcase

			if (p == 1) begin
				push_sample('0, '0);
				push_sample(40'(HALF_TURN), 40'd1);
				push_sample('0, 40'd2);
				push_sample(40'(HALF_TURN + 1), 40'hFF_FFFF_FFFF);
				push_sample(40'(FULL_TURN), '0);
				push_sample(40'hFF_FFFF_FFFF, 40'h80_0000_0000);
				push_sample(40'h80_0000_0000, 40'h7F_FFFF_FFFF);
			end else begin
				push_sample('0, '0);
				push_sample(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
				push_sample(zero_counts, tors_offset[39:0]);
				push_sample(zero_counts - 40'd1, tors_offset[39:0] + 40'd1);
			end

			// mostly smooth motion with random steps either way, some jumps
			mpos = 40'(rand41());
			tpos = 40'(rand41());
			for (int i = 0; i < 240; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					mpos = 40'(rand41());
					tpos = 40'(rand41());
				end else begin
					mpos = mpos + 40'(signed'(32'($urandom)) >>> $urandom_range(0, 30));
					tpos = tpos + 40'(signed'(32'($urandom)) >>> $urandom_range(8, 30));
				end
				push_sample(mpos, tpos);
			end
			drain();
		end

		if (errors == 0 && estimate_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> encoder_angle_velocity_estimator_top.f
sv/eave_pkg.sv
sv/encoder_angle_velocity_estimator_top.sv
dv/encoder_angle_velocity_estimator_top_tb.sv
